/* rtl/core/mfhf_pkg.sv */
// Shared types, constants and fixed-point helpers for the magnet flux feature block.
package mfhf_pkg;

    localparam int DATA_BITS  = 24;
    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS  = DATA_BITS - 4;
    localparam int IND_BITS   = DATA_BITS - 1;
    localparam int HARM_BITS  = 4;
    localparam int PH_W       = 32;
    localparam int TRIG_W     = 32;
    localparam int X_W        = 31;
    localparam int PROD_W     = DATA_BITS + TRIG_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int LPROD_W    = 2 * DATA_BITS;
    localparam int LRND_W     = LPROD_W - FRAC_BITS;
    localparam int DEC_W      = LRND_W + 1;
    localparam int STAGES     = 16;
    localparam int QS_STAGES  = 7;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = IND_BITS;
    localparam logic [CFG_IDX_W-1:0] REG_LD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LQ   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HARM = 2'd2;
    localparam logic [HARM_BITS-1:0] HARM_RESET = 4'd2;

    localparam longint DMAX = (64'sd1 <<< (DATA_BITS - 1)) - 64'sd1;
    localparam longint DMIN = -DMAX - 64'sd1;
    localparam logic signed [TRIG_W-1:0] ONE_Q30 = 32'sh4000_0000;

    // sin(pi*x/2) odd polynomial, Q2.30, lowest order first
    localparam logic [31:0] SINE_COEF [6] = '{
        32'd1686629713, 32'd693598668, 32'd85569306, 32'd5026994, 32'd172272, 32'd3864
    };

    typedef struct packed {
        logic signed [DATA_BITS-1:0] flux_alpha;
        logic signed [DATA_BITS-1:0] flux_beta;
        logic signed [DATA_BITS-1:0] current_d;
        logic signed [DATA_BITS-1:0] current_q;
        logic [ANGLE_BITS-1:0]       rotor_angle;
        logic [ANGLE_BITS-1:0]       phase_offset;
    } t_in;

    typedef struct packed {
        logic signed [DATA_BITS-1:0] fund_alpha;
        logic signed [DATA_BITS-1:0] fund_beta;
        logic signed [DATA_BITS-1:0] harm_alpha;
        logic signed [DATA_BITS-1:0] harm_beta;
    } t_out;

    typedef struct packed {
        logic           neg;
        logic [X_W-1:0] x;
    } t_qarg;

    // Fold a turn phase onto the first quadrant.
    function automatic t_qarg qarg(input logic [PH_W-1:0] ph);
        t_qarg a;
        a.neg = ph[PH_W-1];
        if (ph[PH_W-2]) begin
            a.x = X_W'(ONE_Q30) - {1'b0, ph[PH_W-3:0]};
        end else begin
            a.x = {1'b0, ph[PH_W-3:0]};
        end
        return a;
    endfunction

    // Round half up by 2^30, then clamp to the data range.
    function automatic logic signed [DATA_BITS-1:0] sat_q30(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] t;
        t = (v + (SUM_W'(1) <<< 29)) >>> 30;
        if (t > SUM_W'(DMAX)) begin
            return DATA_BITS'(DMAX);
        end else if (t < SUM_W'(DMIN)) begin
            return DATA_BITS'(DMIN);
        end
        return t[DATA_BITS-1:0];
    endfunction

    function automatic logic signed [DATA_BITS-1:0] sat_dec(input logic signed [DEC_W-1:0] v);
        if (v > DEC_W'(DMAX)) begin
            return DATA_BITS'(DMAX);
        end else if (v < DEC_W'(DMIN)) begin
            return DATA_BITS'(DMIN);
        end
        return v[DATA_BITS-1:0];
    endfunction

endpackage

/* rtl/core/magnet_flux_harmonic_features.sv */
// Top level: magnet flux extraction and fundamental/harmonic feature rotation.
//
// Input channel: i_valid / o_stall carry one sample word (i_data) per accepted
// edge. Output channel: o_valid / i_stall carry one feature word (o_data).
// Configuration: i_cfg_valid / o_cfg_ready write Ld (index 0), Lq (index 1)
// and the harmonic order (index 2); other indexes are dropped. Write config
// only while the pipeline is empty.
//
// Throughput is one word per cycle while i_stall is low, set by a 16-stage
// pipeline: input register, phase fold, a seven-stage quarter-wave sine (one
// multiply per stage), Park rotation, inductance subtraction, inverse Park,
// then both feature rotations in parallel.
// Each stage holds its own valid bit and advances when it is empty or the next
// stage advances, so bubbles collapse: while the output word waits under
// i_stall, new samples keep entering until every stage is full; only then does
// o_stall rise. Stalled words hold in place, nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) empties the pipeline and returns Ld = Lq = 0
// and harmonic order 2.
module magnet_flux_harmonic_features (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  mfhf_pkg::t_in                          i_data,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output mfhf_pkg::t_out                         o_data,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [mfhf_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [mfhf_pkg::CFG_DAT_W-1:0]         i_cfg_data
);
    typedef struct packed {
        logic signed [mfhf_pkg::DATA_BITS-1:0] fa;
        logic signed [mfhf_pkg::DATA_BITS-1:0] fb;
        logic signed [mfhf_pkg::DATA_BITS-1:0] id;
        logic signed [mfhf_pkg::DATA_BITS-1:0] iq;
    } t_cur;

    typedef struct packed {
        logic signed [mfhf_pkg::TRIG_W-1:0] cp;
        logic signed [mfhf_pkg::TRIG_W-1:0] sp;
        logic signed [mfhf_pkg::TRIG_W-1:0] ch;
        logic signed [mfhf_pkg::TRIG_W-1:0] sh;
    } t_trig;

    // configuration
    logic [mfhf_pkg::IND_BITS-1:0]  r_cfg_ld, r_cfg_lq;
    logic [mfhf_pkg::HARM_BITS-1:0] r_cfg_harm;

    // pipeline control
    logic [mfhf_pkg::STAGES-1:0] r_v;
    logic [mfhf_pkg::STAGES-1:0] w_en;

    // datapath registers
    mfhf_pkg::t_in   r_in;
    t_cur            r_cur [1:8];
    mfhf_pkg::t_qarg r_qa  [4];
    t_trig           r_trig [9:13];
    logic signed [mfhf_pkg::LPROD_W-1:0] r_ld_p, r_lq_p;
    logic signed [mfhf_pkg::LRND_W-1:0]  r_li_d, r_li_q;
    logic signed [mfhf_pkg::DATA_BITS-1:0] r_dd, r_qq;

    // combinational
    logic [mfhf_pkg::ANGLE_BITS+mfhf_pkg::HARM_BITS-1:0] w_hmul;
    logic [mfhf_pkg::ANGLE_BITS-1:0] w_hang;
    logic [mfhf_pkg::PH_W-1:0]       w_p, w_hp;
    logic signed [mfhf_pkg::TRIG_W-1:0] w_sp, w_cp, w_sh, w_ch;
    logic signed [mfhf_pkg::LPROD_W-1:0] w_ld_r, w_lq_r;
    logic signed [mfhf_pkg::DATA_BITS-1:0] w_d, w_q, w_ma, w_mb;
    logic signed [mfhf_pkg::DATA_BITS-1:0] w_r0, w_r1, w_r2, w_r3;
    logic signed [mfhf_pkg::DEC_W-1:0] n_dd, n_qq;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ld   <= '0;
            r_cfg_lq   <= '0;
            r_cfg_harm <= mfhf_pkg::HARM_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mfhf_pkg::REG_LD: begin
                    r_cfg_ld <= i_cfg_data;
                end
                mfhf_pkg::REG_LQ: begin
                    r_cfg_lq <= i_cfg_data;
                end
                mfhf_pkg::REG_HARM: begin
                    r_cfg_harm <= i_cfg_data[mfhf_pkg::HARM_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Advance a stage when it is empty or its successor advances.
    always_comb begin
        w_en[mfhf_pkg::STAGES-1] = !r_v[mfhf_pkg::STAGES-1] || !i_stall;
        for (int k = mfhf_pkg::STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_v[mfhf_pkg::STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < mfhf_pkg::STAGES; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Stage 1: turn angles into 32-bit phases and fold each onto a quadrant.
    always_comb begin
        w_hmul = r_cfg_harm * r_in.rotor_angle;
        w_hang = r_in.phase_offset - w_hmul[mfhf_pkg::ANGLE_BITS-1:0];
        w_p    = {r_in.rotor_angle, {(mfhf_pkg::PH_W - mfhf_pkg::ANGLE_BITS){1'b0}}};
        w_hp   = {w_hang, {(mfhf_pkg::PH_W - mfhf_pkg::ANGLE_BITS){1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_in <= i_data;
        end
        if (w_en[1]) begin
            r_cur[1] <= '{fa: r_in.flux_alpha, fb: r_in.flux_beta,
                          id: r_in.current_d, iq: r_in.current_q};
            r_qa[0]  <= mfhf_pkg::qarg(w_p);
            r_qa[1]  <= mfhf_pkg::qarg(w_p + mfhf_pkg::PH_W'(mfhf_pkg::ONE_Q30));
            r_qa[2]  <= mfhf_pkg::qarg(w_hp);
            r_qa[3]  <= mfhf_pkg::qarg(w_hp + mfhf_pkg::PH_W'(mfhf_pkg::ONE_Q30));
        end
        for (int k = 2; k <= 8; k++) begin
            if (w_en[k]) begin
                r_cur[k] <= r_cur[k-1];
            end
        end
    end

    // Stages 2-8: sine and cosine of the rotor and harmonic phases.
    mfhf_qsine u_sin_p (.i_clk(i_clk), .i_en(w_en[8:2]), .i_arg(r_qa[0]), .o_sin(w_sp));
    mfhf_qsine u_cos_p (.i_clk(i_clk), .i_en(w_en[8:2]), .i_arg(r_qa[1]), .o_sin(w_cp));
    mfhf_qsine u_sin_h (.i_clk(i_clk), .i_en(w_en[8:2]), .i_arg(r_qa[2]), .o_sin(w_sh));
    mfhf_qsine u_cos_h (.i_clk(i_clk), .i_en(w_en[8:2]), .i_arg(r_qa[3]), .o_sin(w_ch));

    // Stages 9-10: Park transform, rotate by minus the rotor angle.
    mfhf_rot u_park (
        .i_clk(i_clk), .i_en(w_en[10:9]),
        .i_x(r_cur[8].fa), .i_y(r_cur[8].fb), .i_c(w_cp), .i_s(-w_sp),
        .o_x(w_d), .o_y(w_q)
    );

    // Ld*id and Lq*iq alongside, rounded to the data scale.
    always_comb begin
        w_ld_r = r_ld_p + (mfhf_pkg::LPROD_W'(1) <<< (mfhf_pkg::FRAC_BITS - 1));
        w_lq_r = r_lq_p + (mfhf_pkg::LPROD_W'(1) <<< (mfhf_pkg::FRAC_BITS - 1));
        n_dd   = mfhf_pkg::DEC_W'(w_d) - mfhf_pkg::DEC_W'(r_li_d);
        n_qq   = mfhf_pkg::DEC_W'(w_q) - mfhf_pkg::DEC_W'(r_li_q);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[9]) begin
            r_ld_p    <= $signed({1'b0, r_cfg_ld}) * r_cur[8].id;
            r_lq_p    <= $signed({1'b0, r_cfg_lq}) * r_cur[8].iq;
            r_trig[9] <= '{cp: w_cp, sp: w_sp, ch: w_ch, sh: w_sh};
        end
        if (w_en[10]) begin
            r_li_d <= w_ld_r[mfhf_pkg::LPROD_W-1:mfhf_pkg::FRAC_BITS];
            r_li_q <= w_lq_r[mfhf_pkg::LPROD_W-1:mfhf_pkg::FRAC_BITS];
        end
        // Stage 11: take off the inductive flux.
        if (w_en[11]) begin
            r_dd <= mfhf_pkg::sat_dec(n_dd);
            r_qq <= mfhf_pkg::sat_dec(n_qq);
        end
        for (int k = 10; k <= 13; k++) begin
            if (w_en[k]) begin
                r_trig[k] <= r_trig[k-1];
            end
        end
    end

    // Stages 12-13: inverse Park gives the magnet flux.
    mfhf_rot u_ipark (
        .i_clk(i_clk), .i_en(w_en[13:12]),
        .i_x(r_dd), .i_y(r_qq), .i_c(r_trig[11].cp), .i_s(r_trig[11].sp),
        .o_x(w_ma), .o_y(w_mb)
    );

    // Stages 14-15: fundamental and harmonic features; stage 15 is the output register.
    mfhf_rot u_fund (
        .i_clk(i_clk), .i_en(w_en[15:14]),
        .i_x(w_ma), .i_y(w_mb), .i_c(r_trig[13].cp), .i_s(-r_trig[13].sp),
        .o_x(w_r0), .o_y(w_r1)
    );

    mfhf_rot u_harm (
        .i_clk(i_clk), .i_en(w_en[15:14]),
        .i_x(w_ma), .i_y(w_mb), .i_c(r_trig[13].ch), .i_s(r_trig[13].sh),
        .o_x(w_r2), .o_y(w_r3)
    );

    assign o_data = '{fund_alpha: w_r0, fund_beta: w_r1, harm_alpha: w_r2, harm_beta: w_r3};

`ifndef SYNTHESIS
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall && (&r_v)))
        else $error("input stalled while the pipeline has room");

    a_out_from_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_v[mfhf_pkg::STAGES-2]))
        else $error("output word appeared without a word behind it");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_v[0])
        else $error("accepted word not held in the input stage");

    a_sine_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[8] |-> (w_sp <= mfhf_pkg::ONE_Q30 && w_sp >= -mfhf_pkg::ONE_Q30 &&
                    w_ch <= mfhf_pkg::ONE_Q30 && w_ch >= -mfhf_pkg::ONE_Q30))
        else $error("sine beyond unity");
`endif

endmodule

/* rtl/core/mfhf_qsine.sv */
// Seven-stage quarter-wave sine: square, five Horner steps, final scale and sign.
module mfhf_qsine (
    input  logic                                     i_clk,
    input  logic [mfhf_pkg::QS_STAGES-1:0]           i_en,
    input  mfhf_pkg::t_qarg                          i_arg,
    output logic signed [mfhf_pkg::TRIG_W-1:0]       o_sin
);
    logic [mfhf_pkg::X_W-1:0] r_x   [6];
    logic                     r_neg [6];
    logic [mfhf_pkg::X_W-1:0] r_x2  [5];
    logic [31:0]              r_r   [5];
    logic [31:0]              n_r   [5];
    logic [61:0]              w_sq;
    logic [62:0]              w_hp  [5];
    logic [62:0]              w_fp;
    logic [32:0]              w_mag;
    logic signed [mfhf_pkg::TRIG_W-1:0] n_sin;

    always_comb begin
        w_sq = 62'(i_arg.x) * 62'(i_arg.x);
        for (int j = 0; j < 5; j++) begin
            if (j == 0) begin
                w_hp[j] = 63'(mfhf_pkg::SINE_COEF[5]) * 63'(r_x2[0]);
            end else begin
                w_hp[j] = 63'(r_r[j-1]) * 63'(r_x2[j]);
            end
            n_r[j] = mfhf_pkg::SINE_COEF[4-j] - w_hp[j][61:30];
        end
        w_fp  = 63'(r_r[4]) * 63'(r_x[5]);
        w_mag = w_fp[62:30];
        // clamp to unity
        if (w_mag > 33'(mfhf_pkg::ONE_Q30)) begin
            w_mag = 33'(mfhf_pkg::ONE_Q30);
        end
        n_sin = r_neg[5] ? -$signed(w_mag[31:0]) : $signed(w_mag[31:0]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x[0]   <= i_arg.x;
            r_neg[0] <= i_arg.neg;
            r_x2[0]  <= w_sq[60:30];
        end
        for (int j = 1; j < 6; j++) begin
            if (i_en[j]) begin
                r_x[j]   <= r_x[j-1];
                r_neg[j] <= r_neg[j-1];
            end
        end
        for (int j = 1; j < 5; j++) begin
            if (i_en[j]) begin
                r_x2[j] <= r_x2[j-1];
            end
        end
        for (int j = 0; j < 5; j++) begin
            if (i_en[j+1]) begin
                r_r[j] <= n_r[j];
            end
        end
        if (i_en[6]) begin
            o_sin <= n_sin;
        end
    end

endmodule

/* rtl/core/mfhf_rot.sv */
// Two-stage plane rotation: four products, then rounded and saturated sums.
module mfhf_rot (
    input  logic                                      i_clk,
    input  logic [1:0]                                i_en,
    input  logic signed [mfhf_pkg::DATA_BITS-1:0]     i_x,
    input  logic signed [mfhf_pkg::DATA_BITS-1:0]     i_y,
    input  logic signed [mfhf_pkg::TRIG_W-1:0]        i_c,
    input  logic signed [mfhf_pkg::TRIG_W-1:0]        i_s,
    output logic signed [mfhf_pkg::DATA_BITS-1:0]     o_x,
    output logic signed [mfhf_pkg::DATA_BITS-1:0]     o_y
);
    logic signed [mfhf_pkg::PROD_W-1:0] r_xc, r_ys, r_yc, r_xs;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_xc <= i_x * i_c;
            r_ys <= i_y * i_s;
            r_yc <= i_y * i_c;
            r_xs <= i_x * i_s;
        end
        if (i_en[1]) begin
            o_x <= mfhf_pkg::sat_q30(mfhf_pkg::SUM_W'(r_xc) - mfhf_pkg::SUM_W'(r_ys));
            o_y <= mfhf_pkg::sat_q30(mfhf_pkg::SUM_W'(r_yc) + mfhf_pkg::SUM_W'(r_xs));
        end
    end

endmodule
